// File: design/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 rgb box filter
// pixel layout, register indexes and the divide-by-nine helper
// ----------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

    // red in the lowest byte, matching the stream data layout
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // nine 8-bit samples
    localparam int SUM_W = 12;

    // 2^16 / 9 rounded up, exact floor for sums up to 9 * 255
    localparam logic [12:0] RECIP_NINE = 13'd7282;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
        logic [24:0] prod;
        prod = 25'(sum) * 25'(RECIP_NINE);
        return prod[23:16];
    endfunction

endpackage

`default_nettype wire

// File: design/box_filter_3x3_rgb_top.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_top: streaming 3x3 mean filter on rgb pixels
// two line stores and a 3x3 window; interior pixels get the floored mean of
// their nine neighbours per channel, border pixels pass through
// ----------------------------------------------------------------------------
// the input transfer that completes a window passes the stage 1, window, sum and output
// registers; a pixel's result is caused by the transfer image_width + 1 positions later
// in the stream (flush transfers drain the frame tail); throughput, while the skid stage
// is empty: one transfer per cycle, set by one line store read and one write per cycle
// reset: counters and handshakes cleared at once, sizes back to 640 x 480;
// line stores are not cleared, border handling never reads unwritten entries
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,   // in_red, in_green, in_blue
    input  wire logic                           s_tuser,   // mode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,   // out_red, out_green, out_blue
    output logic                                m_tlast
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);

    // configuration
    logic [bf3_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bf3_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]                 w_eff;
    logic [HGT_W-1:0]                 h_eff;

    // position counters
    logic [COL_W-1:0] in_col_reg, in_col_next, in_col_inc;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next, out_col_inc;
    logic [HGT_W-1:0] out_row_reg, out_row_next, out_row_inc;

    logic             en;
    logic             accept;
    logic             after_frame;
    logic             take;
    logic             emit;
    logic             interior;
    logic             last;
    bf3_pkg::pixel_t  in_pix;
    logic [ADDR_W-1:0] in_addr;

    // stage 1: line store read
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_interior_reg;
    logic              s1_last_reg;
    bf3_pkg::pixel_t   s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    bf3_pkg::pixel_t upper_mem [MAX_WIDTH];
    bf3_pkg::pixel_t middle_mem [MAX_WIDTH];
    bf3_pkg::pixel_t top_rd_reg;
    bf3_pkg::pixel_t mid_rd_reg;
    logic            fwd_reg;
    bf3_pkg::pixel_t fwd_top_reg;
    bf3_pkg::pixel_t fwd_mid_reg;
    bf3_pkg::pixel_t top_eff;
    bf3_pkg::pixel_t mid_eff;

    // stage 2: window
    bf3_pkg::pixel_t win_reg [9];
    logic            s2_valid_reg;
    logic            s2_interior_reg;
    logic            s2_last_reg;
    logic [bf3_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue;

    // stage 3: sums
    logic                      s3_valid_reg;
    logic                      s3_interior_reg;
    logic                      s3_last_reg;
    logic [bf3_pkg::SUM_W-1:0] s3_red_reg, s3_green_reg, s3_blue_reg;
    bf3_pkg::pixel_t           s3_center_reg;
    bf3_pkg::pixel_t           res_pix;
    logic                      res_valid;

    // output register and skid stage
    logic            out_valid_reg, out_valid_next;
    bf3_pkg::pixel_t out_pix_reg;
    logic            out_last_reg;
    logic            skid_valid_reg, skid_valid_next;
    bf3_pkg::pixel_t skid_pix_reg;
    logic            skid_last_reg;
    logic            load_out;
    logic            load_skid;
    logic            out_from_skid;

    // ------------------------------------------------------------------------
    // effective frame size
    // ------------------------------------------------------------------------
    always_comb
    begin
        priority if (width_reg == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = COL_W'(width_reg);
        end

        priority if (height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HGT_W'(height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bf3_pkg::WIDTH_RESET;
            height_reg <= bf3_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bf3_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_wdata[bf3_pkg::WIDTH_REG_W-1:0];
                end
                bf3_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_wdata[bf3_pkg::HEIGHT_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input side: item decode and position tracking
    // ------------------------------------------------------------------------
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    assign after_frame = in_row_reg >= ROW_W'(h_eff);
    // flush before the frame is complete is dropped
    assign take        = accept && !(s_tuser && !after_frame);
    assign in_pix      = after_frame ? bf3_pkg::pixel_t'('0) : bf3_pkg::pixel_t'(s_tdata);
    assign in_addr     = in_col_reg[ADDR_W-1:0];

    assign in_col_inc  = COL_W'(in_col_reg + COL_W'(1));
    assign out_col_inc = COL_W'(out_col_reg + COL_W'(1));
    assign out_row_inc = HGT_W'(out_row_reg + HGT_W'(1));

    assign emit     = (in_row_reg >= ROW_W'(2)) ||
                      ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign interior = (out_row_reg != '0) && (out_row_inc < h_eff) &&
                      (out_col_reg != '0) && (out_col_inc < w_eff);
    assign last     = (out_row_inc >= h_eff) && (out_col_inc >= w_eff);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = ROW_W'(in_row_reg + ROW_W'(1));
            end
            else
            begin
                in_col_next = in_col_inc;
            end

            if (emit)
            begin
                priority if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc;
                end
                else
                begin
                    out_col_next = out_col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: line store access
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && take)
        begin
            s1_emit_reg     <= emit;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
            s1_pix_reg      <= in_pix;
            s1_addr_reg     <= in_addr;
            top_rd_reg      <= upper_mem[in_addr];
            mid_rd_reg      <= middle_mem[in_addr];
            // single-column frames hit the entry still being written
            fwd_reg         <= s1_valid_reg && (s1_addr_reg == in_addr);
            fwd_top_reg     <= mid_eff;
            fwd_mid_reg     <= s1_pix_reg;
        end
        if (en && s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_eff;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    assign top_eff = fwd_reg ? fwd_top_reg : top_rd_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    // ------------------------------------------------------------------------
    // stage 2: window shift
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= top_eff;
            win_reg[5] <= mid_eff;
            win_reg[8] <= s1_pix_reg;
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_comb
    begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum_red   = sum_red   + bf3_pkg::SUM_W'(win_reg[i].red);
            sum_green = sum_green + bf3_pkg::SUM_W'(win_reg[i].green);
            sum_blue  = sum_blue  + bf3_pkg::SUM_W'(win_reg[i].blue);
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: divide and select
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_valid_reg)
        begin
            s3_interior_reg <= s2_interior_reg;
            s3_last_reg     <= s2_last_reg;
            s3_red_reg      <= sum_red;
            s3_green_reg    <= sum_green;
            s3_blue_reg     <= sum_blue;
            s3_center_reg   <= win_reg[4];
        end
    end

    always_comb
    begin
        if (s3_interior_reg)
        begin
            res_pix.red   = bf3_pkg::div9(s3_red_reg);
            res_pix.green = bf3_pkg::div9(s3_green_reg);
            res_pix.blue  = bf3_pkg::div9(s3_blue_reg);
        end
        else
        begin
            res_pix = s3_center_reg;
        end
    end

    assign res_valid = en && s3_valid_reg;

    // ------------------------------------------------------------------------
    // output register with skid stage
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        priority if (out_valid_reg && m_tready)
        begin
            priority if (skid_valid_reg)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
            begin
                load_out = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg)
        begin
            if (res_valid)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
        end
        else
        begin
            if (res_valid)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (load_out)
        begin
            out_pix_reg  <= res_pix;
            out_last_reg <= s3_last_reg;
        end
        else if (out_from_skid)
        begin
            out_pix_reg  <= skid_pix_reg;
            out_last_reg <= skid_last_reg;
        end
        if (load_skid)
        begin
            skid_pix_reg  <= res_pix;
            skid_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: design/bf3_checker.sv
// ----------------------------------------------------------------------------
// bf3_checker: port-level checks for the 3x3 rgb box filter
// watches both stream sides and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // input back-pressure only while a result is waiting
    a_ready_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // ready drops only after an output stall
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // a stalled input is ready again in the cycle after the output is taken
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("input still stalled after skid drained");

endmodule

bind box_filter_3x3_rgb_top bf3_checker u_bf3_checker (.*);

`default_nettype wire
